/* hw/rtl/rv64ie_pkg.sv */
// ----------------------------------------------------------------------------
// rv64ie_pkg
// Shared types, constants and helpers of the RV64IM instruction executor.
// ----------------------------------------------------------------------------
`default_nettype none

package rv64ie_pkg;

  localparam int unsigned MEM_BYTES = 65536;
  localparam int unsigned MEM_AW    = $clog2(MEM_BYTES);
  localparam int unsigned XLEN      = 64;
  localparam int unsigned NREGS     = 32;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned MUL_STEPS = 5;
  localparam int unsigned DIV_STEPS = 64;
  localparam int unsigned IN_W      = 120;
  localparam int unsigned OUT_W     = 336;
  localparam int unsigned OUT_USED  = 329;

  typedef enum logic [4:0] {
    OPC_LOAD    = 5'h00,
    OPC_OPIMM   = 5'h04,
    OPC_AUIPC   = 5'h05,
    OPC_OPIMM32 = 5'h06,
    OPC_STORE   = 5'h08,
    OPC_OP      = 5'h0C,
    OPC_LUI     = 5'h0D,
    OPC_OP32    = 5'h0E,
    OPC_BRANCH  = 5'h18,
    OPC_JALR    = 5'h19,
    OPC_JAL     = 5'h1B
  } opcode_e;

  typedef enum logic [2:0] {
    K_SIMPLE,
    K_LOAD,
    K_STORE,
    K_MUL,
    K_DIV
  } kind_e;

  typedef struct packed {
    logic clear;
    logic accept;
    logic opnd;
    logic exec;
    logic mem_wr;
    logic mem_rd;
    logic ld_fin;
    logic mul_step;
    logic mul_fin;
    logic div_step;
    logic div_fin;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic  clr_done;
    logic  mem_done;
    logic  mul_done;
    logic  div_done;
    kind_e kind;
  } dp_sts_t;

  function automatic logic [XLEN-1:0] sext32(input logic [XLEN-1:0] x);
    return {{32{x[31]}}, x[31:0]};
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/rv64ie_ram.sv */
// ----------------------------------------------------------------------------
// rv64ie_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rv64ie_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* hw/rtl/rv64ie_dp.sv */
// ----------------------------------------------------------------------------
// rv64ie_dp
// Datapath: register file, pc, decode and alu, byte-serial data memory,
// 32x32 partial-product multiplier and radix-2 divider.
// ----------------------------------------------------------------------------
`default_nettype none

module rv64ie_dp import rv64ie_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [XLEN-1:0]  cfg_wdata_i,
  input  wire logic             in_preload_i,
  input  wire logic [31:0]      in_instr_i,
  input  wire logic             in_no_jump_i,
  input  wire logic [15:0]      in_paddr_i,
  input  wire logic [XLEN-1:0]  in_pdata_i,
  input  wire dp_cmd_t          cmd_i,
  output dp_sts_t               sts_o,
  output logic      [OUT_W-1:0] out_data_o
);

  localparam logic [XLEN-1:0] SIGN64 = {1'b1, {(XLEN-1){1'b0}}};

  logic [XLEN-1:0]   pc_q;
  logic [NREGS-1:0]  rf_vld_q;
  logic [MEM_AW-1:0] clr_cnt_q;

  logic [31:0]       ir_q;
  logic              nojump_q;
  logic [4:0]        rd_q;
  logic [XLEN-1:0]   npc_q, v_q, old_q, rs1_q, rs2_q;
  logic              wr_q, isw_q;
  logic [XLEN-1:0]   st_addr_q, st_data_q;
  logic [3:0]        st_w_q;
  logic [MEM_AW-1:0] mem_base_q;
  logic [XLEN-1:0]   mem_wdata_q;
  logic [3:0]        mem_len_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [XLEN-1:0]   ld_q;
  logic [XLEN-1:0]   op_a_q, op_b_q;
  logic [127:0]      acc_q;
  logic [XLEN-1:0]   pp_q;
  logic [XLEN-1:0]   rem_q, dvd_q, dvs_q;
  logic              na_q, nb_q, bz_q, ovf_q;
  logic [OUT_W-1:0]  out_q;

  // field decode
  opcode_e         op;
  logic [2:0]      f3;
  logic [4:0]      rs1i, rs2i;
  logic            b30, m_ext, full;
  logic [XLEN-1:0] imm_i, imm_s, imm_b, imm_u, imm_j;

  assign op    = opcode_e'(ir_q[6:2]);
  assign f3    = ir_q[14:12];
  assign rs1i  = ir_q[19:15];
  assign rs2i  = ir_q[24:20];
  assign b30   = ir_q[30];
  assign m_ext = ir_q[25];
  assign full  = (ir_q[1:0] == 2'b11);
  assign imm_i = {{52{ir_q[31]}}, ir_q[31:20]};
  assign imm_s = {{52{ir_q[31]}}, ir_q[31:25], ir_q[11:7]};
  assign imm_b = {{51{ir_q[31]}}, ir_q[31], ir_q[7], ir_q[30:25], ir_q[11:8], 1'b0};
  assign imm_u = {{32{ir_q[31]}}, ir_q[31:12], 12'b0};
  assign imm_j = {{43{ir_q[31]}}, ir_q[31], ir_q[19:12], ir_q[20], ir_q[30:21], 1'b0};

  // register file: two copies for two read ports
  logic            rf_we;
  logic [XLEN-1:0] rf_rda, rf_rdb, dval;
  logic [4:0]      rf_raddr_a;

  assign rf_raddr_a = cmd_i.opnd ? rd_q : rs1i;
  assign rf_we      = cmd_i.finish && wr_q && (rd_q != '0);

  rv64ie_ram #(.WIDTH(XLEN), .DEPTH(NREGS)) u_rf_a (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rd_q),
    .wdata_i (dval),
    .raddr_i (rf_raddr_a),
    .rdata_o (rf_rda)
  );

  rv64ie_ram #(.WIDTH(XLEN), .DEPTH(NREGS)) u_rf_b (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rd_q),
    .wdata_i (dval),
    .raddr_i (rs2i),
    .rdata_o (rf_rdb)
  );

  // data memory, one byte per cycle
  logic              dm_we;
  logic [MEM_AW-1:0] dm_waddr, dm_raddr, mem_addr;
  logic [7:0]        dm_wdata, dm_rdata;
  logic              mem_done;

  assign mem_done = (cnt_q == CNT_W'(mem_len_q));
  assign mem_addr = mem_base_q + MEM_AW'(cnt_q);
  assign dm_raddr = mem_addr;

  always_comb begin
    dm_we    = 1'b0;
    dm_waddr = mem_addr;
    dm_wdata = mem_wdata_q[{cnt_q[2:0], 3'b000} +: 8];
    if (cmd_i.clear) begin
      dm_we    = 1'b1;
      dm_waddr = clr_cnt_q;
      dm_wdata = '0;
    end else if (cmd_i.mem_wr && !mem_done) begin
      dm_we = 1'b1;
    end
  end

  rv64ie_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_dmem (
    .clk_i   (clk_i),
    .we_i    (dm_we),
    .waddr_i (dm_waddr),
    .wdata_i (dm_wdata),
    .raddr_i (dm_raddr),
    .rdata_o (dm_rdata)
  );

  // alu
  logic            is_reg, is_w, sub;
  logic [XLEN-1:0] opb, sum, srl_in, sra_in, alu;
  logic [5:0]      shamt;
  logic            eq, lt, ltu, take;

  assign is_reg = (op == OPC_OP) || (op == OPC_OP32);
  assign is_w   = (op == OPC_OPIMM32) || (op == OPC_OP32);
  assign opb    = is_reg ? rs2_q : imm_i;
  assign shamt  = {~is_w & opb[5], opb[4:0]};
  assign sub    = is_reg && b30;
  assign sum    = sub ? (rs1_q - opb) : (rs1_q + opb);
  assign srl_in = is_w ? {32'b0, rs1_q[31:0]} : rs1_q;
  assign sra_in = is_w ? sext32(rs1_q) : rs1_q;
  assign eq     = (rs1_q == rs2_q);
  assign lt     = ($signed(rs1_q) < $signed(rs2_q));
  assign ltu    = (rs1_q < rs2_q);

  always_comb begin
    case (f3)
      3'd0:    alu = sum;
      3'd1:    alu = rs1_q << shamt;
      3'd2:    alu = {63'b0, $signed(rs1_q) < $signed(opb)};
      3'd3:    alu = {63'b0, rs1_q < opb};
      3'd4:    alu = rs1_q ^ opb;
      3'd5:    alu = b30 ? XLEN'($signed(sra_in) >>> shamt) : (srl_in >> shamt);
      3'd6:    alu = rs1_q | opb;
      default: alu = rs1_q & opb;
    endcase
    case (f3)
      3'd0:    take = eq;
      3'd1:    take = !eq;
      3'd4:    take = lt;
      3'd5:    take = !lt;
      3'd6:    take = ltu;
      3'd7:    take = !ltu;
      default: take = 1'b0;
    endcase
  end

  // instruction decode
  kind_e           kind;
  logic            wr, word, jump;
  logic [XLEN-1:0] v, target, npc, saddr, laddr, sdata, dv_a, dv_b;
  logic [3:0]      st_w;
  logic            dsgn;

  assign saddr = rs1_q + imm_s;
  assign laddr = rs1_q + imm_i;
  assign dsgn  = !f3[0];
  assign dv_a  = !is_w ? rs1_q : (dsgn ? sext32(rs1_q) : {32'b0, rs1_q[31:0]});
  assign dv_b  = !is_w ? rs2_q : (dsgn ? sext32(rs2_q) : {32'b0, rs2_q[31:0]});

  always_comb begin
    case (f3[1:0])
      2'd0:    sdata = {56'b0, rs2_q[7:0]};
      2'd1:    sdata = {48'b0, rs2_q[15:0]};
      2'd2:    sdata = {32'b0, rs2_q[31:0]};
      default: sdata = rs2_q;
    endcase
  end

  always_comb begin
    kind   = K_SIMPLE;
    wr     = 1'b0;
    word   = 1'b0;
    jump   = 1'b0;
    v      = alu;
    target = pc_q + imm_b;
    st_w   = '0;
    if (full) begin
      unique case (op)
        OPC_LOAD: begin
          if (f3 != 3'd7) begin
            kind = K_LOAD;
            wr   = 1'b1;
          end
        end
        OPC_OPIMM: wr = 1'b1;
        OPC_AUIPC: begin
          wr = 1'b1;
          v  = pc_q + imm_u;
        end
        OPC_OPIMM32: begin
          word = 1'b1;
          wr   = (f3 == 3'd0) || (f3 == 3'd1) || (f3 == 3'd5);
        end
        OPC_STORE: begin
          if (!f3[2]) begin
            kind = K_STORE;
            st_w = 4'd1 << f3[1:0];
          end
        end
        OPC_OP: begin
          wr = 1'b1;
          if (m_ext) begin
            kind = f3[2] ? K_DIV : K_MUL;
          end
        end
        OPC_LUI: begin
          wr = 1'b1;
          v  = imm_u;
        end
        OPC_OP32: begin
          word = 1'b1;
          if (m_ext) begin
            if (f3 == 3'd0) begin
              wr   = 1'b1;
              kind = K_MUL;
            end else if (f3[2]) begin
              wr   = 1'b1;
              kind = K_DIV;
            end
          end else begin
            wr = (f3 == 3'd0) || (f3 == 3'd1) || (f3 == 3'd5);
          end
        end
        OPC_BRANCH: jump = take;
        OPC_JALR: begin
          jump   = 1'b1;
          target = laddr & ~XLEN'(1);
          v      = pc_q + XLEN'(4);
          wr     = 1'b1;
        end
        OPC_JAL: begin
          jump   = 1'b1;
          target = pc_q + imm_j;
          v      = pc_q + XLEN'(4);
          wr     = 1'b1;
        end
        default: ;
      endcase
    end
    if (!full) begin
      npc = pc_q + XLEN'(2);
    end else if (jump && !nojump_q) begin
      npc = target;
    end else begin
      npc = pc_q + XLEN'(4);
    end
  end

  // multiplier and divider helpers
  logic [31:0]     a_half, b_half;
  logic [1:0]      pidx;
  logic [2:0]      lidx;
  logic [127:0]    pp_sh;
  logic [XLEN-1:0] hi, hi_ca, hi_cb;
  logic [XLEN:0]   rem_sh, diff;
  logic [XLEN-1:0] q_fix, r_fix;

  assign a_half = cnt_q[0] ? op_a_q[63:32] : op_a_q[31:0];
  assign b_half = cnt_q[1] ? op_b_q[63:32] : op_b_q[31:0];
  assign pidx   = 2'(cnt_q - CNT_W'(1));
  assign lidx   = 3'(cnt_q - CNT_W'(1));

  always_comb begin
    case (pidx)
      2'd0:    pp_sh = {64'b0, pp_q};
      2'd3:    pp_sh = {pp_q, 64'b0};
      default: pp_sh = {32'b0, pp_q, 32'b0};
    endcase
  end

  assign hi_ca = (((f3 == 3'd1) || (f3 == 3'd2)) && op_a_q[63]) ? op_b_q : '0;
  assign hi_cb = ((f3 == 3'd1) && op_b_q[63]) ? op_a_q : '0;
  assign hi    = acc_q[127:64] - hi_ca - hi_cb;

  assign rem_sh = {rem_q, dvd_q[63]};
  assign diff   = rem_sh - {1'b0, dvs_q};

  always_comb begin
    q_fix = (na_q ^ nb_q) ? (XLEN'(0) - dvd_q) : dvd_q;
    r_fix = na_q ? (XLEN'(0) - rem_q) : rem_q;
    if (bz_q) begin
      q_fix = '1;
      r_fix = op_a_q;
    end else if (ovf_q) begin
      q_fix = op_a_q;
      r_fix = '0;
    end
  end

  // writeback value
  logic [XLEN-1:0] vf;
  assign vf   = isw_q ? sext32(v_q) : v_q;
  assign dval = (wr_q && (rd_q != '0)) ? vf : old_q;

  // control-side registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q      <= '0;
      rf_vld_q  <= '0;
      clr_cnt_q <= '0;
    end else begin
      if (cmd_i.clear) begin
        clr_cnt_q <= clr_cnt_q + MEM_AW'(1);
      end
      if (rf_we) begin
        rf_vld_q[rd_q] <= 1'b1;
      end
      if (cfg_we_i) begin
        pc_q <= cfg_wdata_i;
      end else if (cmd_i.finish) begin
        pc_q <= npc_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ir_q        <= in_instr_i;
      nojump_q    <= in_no_jump_i;
      rd_q        <= in_preload_i ? 5'd0 : in_instr_i[11:7];
      npc_q       <= pc_q;
      wr_q        <= 1'b0;
      isw_q       <= 1'b0;
      old_q       <= '0;
      st_addr_q   <= '0;
      st_data_q   <= '0;
      st_w_q      <= '0;
      mem_base_q  <= MEM_AW'(in_paddr_i);
      mem_wdata_q <= in_pdata_i;
      mem_len_q   <= 4'd8;
      cnt_q       <= '0;
    end
    if (cmd_i.opnd) begin
      rs1_q <= rf_vld_q[rs1i] ? rf_rda : '0;
      rs2_q <= rf_vld_q[rs2i] ? rf_rdb : '0;
    end
    if (cmd_i.exec) begin
      old_q       <= rf_vld_q[rd_q] ? rf_rda : '0;
      npc_q       <= npc;
      wr_q        <= wr;
      isw_q       <= word;
      v_q         <= v;
      st_addr_q   <= (kind == K_STORE) ? saddr : '0;
      st_data_q   <= (kind == K_STORE) ? sdata : '0;
      st_w_q      <= st_w;
      mem_base_q  <= (kind == K_STORE) ? saddr[MEM_AW-1:0] : laddr[MEM_AW-1:0];
      mem_wdata_q <= sdata;
      mem_len_q   <= (kind == K_STORE) ? st_w : (4'd1 << f3[1:0]);
      cnt_q       <= '0;
      ld_q        <= '0;
      op_a_q      <= (kind == K_DIV) ? dv_a : rs1_q;
      op_b_q      <= (kind == K_DIV) ? dv_b : rs2_q;
      acc_q       <= '0;
      na_q        <= dsgn && dv_a[63];
      nb_q        <= dsgn && dv_b[63];
      dvd_q       <= (dsgn && dv_a[63]) ? (XLEN'(0) - dv_a) : dv_a;
      dvs_q       <= (dsgn && dv_b[63]) ? (XLEN'(0) - dv_b) : dv_b;
      rem_q       <= '0;
      bz_q        <= (dv_b == '0);
      ovf_q       <= dsgn && (dv_a == SIGN64) && (dv_b == '1);
    end
    if (cmd_i.mem_wr && !mem_done) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
    if (cmd_i.mem_rd) begin
      // read for byte cnt is issued now, byte cnt-1 lands now
      if (cnt_q != '0) begin
        ld_q[{lidx, 3'b000} +: 8] <= dm_rdata;
      end
      if (!mem_done) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
    if (cmd_i.ld_fin) begin
      if (f3[2]) begin
        v_q <= ld_q;
      end else begin
        case (f3[1:0])
          2'd0:    v_q <= {{56{ld_q[7]}}, ld_q[7:0]};
          2'd1:    v_q <= {{48{ld_q[15]}}, ld_q[15:0]};
          2'd2:    v_q <= sext32(ld_q);
          default: v_q <= ld_q;
        endcase
      end
    end
    if (cmd_i.mul_step) begin
      pp_q  <= a_half * b_half;
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q != '0) begin
        acc_q <= acc_q + pp_sh;
      end
    end
    if (cmd_i.mul_fin) begin
      v_q <= (f3 == 3'd0) ? acc_q[63:0] : hi;
    end
    if (cmd_i.div_step) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (!diff[XLEN]) begin
        rem_q <= diff[XLEN-1:0];
        dvd_q <= {dvd_q[62:0], 1'b1};
      end else begin
        rem_q <= rem_sh[XLEN-1:0];
        dvd_q <= {dvd_q[62:0], 1'b0};
      end
    end
    if (cmd_i.div_fin) begin
      v_q <= f3[1] ? r_fix : q_fix;
    end
    if (cmd_i.finish) begin
      out_q <= {(OUT_W-OUT_USED)'(0), st_w_q, st_data_q, st_addr_q, dval, rd_q, npc_q, pc_q};
    end
  end

  assign sts_o.clr_done = (clr_cnt_q == '1);
  assign sts_o.mem_done = mem_done;
  assign sts_o.mul_done = (cnt_q == CNT_W'(MUL_STEPS));
  assign sts_o.div_done = (cnt_q == CNT_W'(DIV_STEPS));
  assign sts_o.kind     = kind;
  assign out_data_o     = out_q;

endmodule

`default_nettype wire

/* hw/rtl/rv64ie_ctrl.sv */
// ----------------------------------------------------------------------------
// rv64ie_ctrl
// Sequencer: memory clearing, request intake, dispatch to the execution
// units and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module rv64ie_ctrl import rv64ie_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  input  wire logic    in_preload_i,
  input  wire logic    out_ready_i,
  input  wire dp_sts_t sts_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  output dp_cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PRE,
    S_RD,
    S_OPND,
    S_EXEC,
    S_LD,
    S_LDX,
    S_ST,
    S_MUL,
    S_MULF,
    S_DIV,
    S_DIVF,
    S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;
  logic   out_free;

  assign out_free = !out_vld_q || out_ready_i;

  always_comb begin
    state_d   = state_q;
    out_vld_d = out_vld_q && !out_ready_i;
    cmd_o     = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = in_preload_i ? S_PRE : S_RD;
        end
      end
      S_PRE: begin
        cmd_o.mem_wr = 1'b1;
        if (sts_i.mem_done) begin
          state_d = S_FIN;
        end
      end
      S_RD:   state_d = S_OPND;
      S_OPND: begin
        cmd_o.opnd = 1'b1;
        state_d    = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        unique case (sts_i.kind)
          K_LOAD:  state_d = S_LD;
          K_STORE: state_d = S_ST;
          K_MUL:   state_d = S_MUL;
          K_DIV:   state_d = S_DIV;
          default: state_d = S_FIN;
        endcase
      end
      S_LD: begin
        cmd_o.mem_rd = 1'b1;
        if (sts_i.mem_done) begin
          state_d = S_LDX;
        end
      end
      S_LDX: begin
        cmd_o.ld_fin = 1'b1;
        state_d      = S_FIN;
      end
      S_ST: begin
        cmd_o.mem_wr = 1'b1;
        if (sts_i.mem_done) begin
          state_d = S_FIN;
        end
      end
      S_MUL: begin
        if (sts_i.mul_done) begin
          state_d = S_MULF;
        end else begin
          cmd_o.mul_step = 1'b1;
        end
      end
      S_MULF: begin
        cmd_o.mul_fin = 1'b1;
        state_d       = S_FIN;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_DIVF;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_DIVF: begin
        cmd_o.div_fin = 1'b1;
        state_d       = S_FIN;
      end
      S_FIN: begin
        // hold until the output register can take the result
        if (out_free) begin
          cmd_o.finish = 1'b1;
          out_vld_d    = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_vld_q;

endmodule

`default_nettype wire

/* hw/rtl/rv64im_instruction_executor.sv */
// ----------------------------------------------------------------------------
// rv64im_instruction_executor
// Runs one RV64IM instruction (or one eight-byte memory preload) per request.
// ----------------------------------------------------------------------------
// channel   dir  signals                         content
// s_axis    in   tvalid/tready/tdata/tuser       instruction or preload request
// m_axis    out  tvalid/tready/tdata             execution result
// cfg       in   cfg_we_i/cfg_wdata_i            reset_pc, also loads the pc
//
// Load and store move one data memory byte per cycle; multiply sums four
// 32x32 partial products; divide forms one quotient bit per cycle.
// After reset a clearing pass writes zero to all 65536 data memory bytes,
// one per cycle, before the first request is taken.
// A result waits in the output register; a new request is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module rv64im_instruction_executor import rv64ie_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [XLEN-1:0]  cfg_wdata_i,
  input  wire logic             s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // instruction[31:0], no_jump[32], preload_addr[48:33], preload_data[112:49]
  input  wire logic [IN_W-1:0]  s_axis_tdata_i,
  // action[0]
  input  wire logic             s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  // exec_pc[63:0], next_pc[127:64], dest_index[132:128], dest_value[196:133],
  // store_addr[260:197], store_data[324:261], store_width[328:325]
  output logic      [OUT_W-1:0] m_axis_tdata_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  rv64ie_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_preload_i (s_axis_tuser_i),
    .out_ready_i  (m_axis_tready_i),
    .sts_i        (sts),
    .in_ready_o   (s_axis_tready_o),
    .out_valid_o  (m_axis_tvalid_o),
    .cmd_o        (cmd)
  );

  rv64ie_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_preload_i (s_axis_tuser_i),
    .in_instr_i   (s_axis_tdata_i[31:0]),
    .in_no_jump_i (s_axis_tdata_i[32]),
    .in_paddr_i   (s_axis_tdata_i[48:33]),
    .in_pdata_i   (s_axis_tdata_i[112:49]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_data_o   (m_axis_tdata_o)
  );

`ifndef SYNTH
  a_fin_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("result loaded while output register still held");

  a_accept_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("request intake stayed open after accept");

  a_fin_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> m_axis_tvalid_o)
    else $error("finished result not presented");

  a_no_clear_while_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clear |-> !s_axis_tready_o)
    else $error("request taken during memory clearing");
`endif

endmodule

`default_nettype wire

/* dv/tb_rv64im_instruction_executor.sv */
// ----------------------------------------------------------------------------
// tb_rv64im_instruction_executor
// Drives RV64IM instructions and memory preloads into the executor, predicts
// every result with an in-bench model of registers, pc and data memory, and
// compares each result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rv64im_instruction_executor;
  import rv64ie_pkg::*;

  localparam int unsigned MAX_CYCLES = 3000000;

  // packed from the top bit down, so exec_pc lands in the lowest bits
  typedef struct packed {
    logic [3:0]  store_width;
    logic [63:0] store_data;
    logic [63:0] store_addr;
    logic [63:0] dest_value;
    logic [4:0]  dest_index;
    logic [63:0] next_pc;
    logic [63:0] exec_pc;
  } exec_result_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [XLEN-1:0]  cfg_wdata_i;
  logic             s_axis_tvalid_i;
  logic             s_axis_tready_o;
  logic [IN_W-1:0]  s_axis_tdata_i;
  logic             s_axis_tuser_i;
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata_o;

  rv64im_instruction_executor dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // model state
  logic [63:0]  xreg [32];
  logic [63:0]  pc_q;
  logic [7:0]   dmem [MEM_BYTES];
  exec_result_t expected_q [$];
  int           errors = 0;
  int           cycle_cnt = 0;
  int           burst_left;
  logic         stall_mode = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  // receiver stalls on a slowly changing pattern
  always @(posedge clk_i) begin
    if (($urandom % 64) == 0) stall_mode <= ~stall_mode;
    m_axis_tready_i <= stall_mode ? (($urandom % 4) == 0) : (($urandom % 8) != 0);
  end

  always @(posedge clk_i) begin
    exec_result_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[OUT_USED-1:0];
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", got.exec_pc, 64'h0);
      end else begin
        want = expected_q.pop_front();
        if (got.exec_pc !== want.exec_pc)
          report_mismatch("exec_pc", got.exec_pc, want.exec_pc);
        if (got.next_pc !== want.next_pc)
          report_mismatch("next_pc", got.next_pc, want.next_pc);
        if (got.dest_index !== want.dest_index)
          report_mismatch("dest_index", 64'(got.dest_index), 64'(want.dest_index));
        if (got.dest_value !== want.dest_value)
          report_mismatch("dest_value", got.dest_value, want.dest_value);
        if (got.store_addr !== want.store_addr)
          report_mismatch("store_addr", got.store_addr, want.store_addr);
        if (got.store_data !== want.store_data)
          report_mismatch("store_data", got.store_data, want.store_data);
        if (got.store_width !== want.store_width)
          report_mismatch("store_width", 64'(got.store_width), 64'(want.store_width));
      end
    end
  end

  function automatic logic [63:0] mem_rd(logic [63:0] addr, int n);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < n; i++) v[8*i +: 8] = dmem[16'(addr + 64'(i))];
    return v;
  endfunction

  task automatic mem_wr(logic [63:0] addr, logic [63:0] v, int n);
    for (int i = 0; i < n; i++) dmem[16'(addr + 64'(i))] = v[8*i +: 8];
  endtask

  function automatic logic [63:0] sx(logic [63:0] x, int w);
    logic [63:0] m;
    m = (w >= 64) ? '1 : ((64'd1 << w) - 1);
    return (w >= 64) ? x : (((x & m) ^ (64'd1 << (w - 1))) - (64'd1 << (w - 1)));
  endfunction

  function automatic logic [63:0] mul_div(logic [2:0] f3, logic [63:0] a, logic [63:0] b);
    logic signed [127:0] p;
    case (f3)
      3'd0: return a * b;
      3'd1: begin p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b}); return p[127:64]; end
      3'd2: begin p = $signed({{64{a[63]}}, a}) * $signed({64'd0, b}); return p[127:64]; end
      3'd3: begin p = {64'd0, a} * {64'd0, b}; return p[127:64]; end
      3'd4: begin
        if (b == 0) return '1;
        if (a == 64'h8000_0000_0000_0000 && b == '1) return a;
        return $signed(a) / $signed(b);
      end
      3'd5: return (b == 0) ? '1 : a / b;
      3'd6: begin
        if (b == 0) return a;
        if (a == 64'h8000_0000_0000_0000 && b == '1) return '0;
        return $signed(a) % $signed(b);
      end
      default: return (b == 0) ? a : a % b;
    endcase
  endfunction

  // predicts one request and updates the model state
  task automatic predict_step(input logic action, input logic [31:0] ir, input logic no_jump,
                              input logic [15:0] paddr, input logic [63:0] pdata);
    exec_result_t r;
    logic [63:0] a, b, imm, v, target, npc, off;
    logic [4:0] rd;
    logic [2:0] f3;
    logic b30, wr, jump, take;
    logic [5:0] sh;
    int n;
    r = '0;
    if (action) begin
      mem_wr(64'(paddr), pdata, 8);
      r.exec_pc = pc_q;
      r.next_pc = pc_q;
      expected_q.push_back(r);
      return;
    end
    rd = ir[11:7]; f3 = ir[14:12];
    a = xreg[ir[19:15]]; b = xreg[ir[24:20]];
    b30 = ir[30]; imm = sx(64'(ir[31:20]), 12);
    v = '0; wr = 1'b0; jump = 1'b0; target = '0;
    if (ir[1:0] != 2'b11) begin
      npc = pc_q + 2;
    end else begin
      npc = pc_q + 4;
      case (ir[6:2])
        OPC_LOAD: if (f3 != 3'd7) begin
          n = 1 << f3[1:0];
          v = mem_rd(a + imm, n);
          if (!f3[2] && n < 8) v = sx(v, 8 * n);
          wr = 1'b1;
        end
        OPC_OPIMM: begin
          sh = imm[5:0]; wr = 1'b1;
          case (f3)
            3'd0: v = a + imm;
            3'd1: v = a << sh;
            3'd2: v = 64'($signed(a) < $signed(imm));
            3'd3: v = 64'(a < imm);
            3'd4: v = a ^ imm;
            3'd5: v = b30 ? 64'($signed(a) >>> sh) : a >> sh;
            3'd6: v = a | imm;
            default: v = a & imm;
          endcase
        end
        OPC_AUIPC: begin v = pc_q + sx(64'({ir[31:12], 12'd0}), 32); wr = 1'b1; end
        OPC_OPIMM32: begin
          sh = {1'b0, imm[4:0]};
          if (f3 == 3'd0) begin v = sx(a + imm, 32); wr = 1'b1; end
          else if (f3 == 3'd1) begin v = sx(a << sh, 32); wr = 1'b1; end
          else if (f3 == 3'd5) begin
            v = b30 ? sx(64'($signed(sx(a, 32)) >>> sh), 32) : sx({32'd0, a[31:0]} >> sh, 32);
            wr = 1'b1;
          end
        end
        OPC_STORE: if (f3 < 3'd4) begin
          n = 1 << f3;
          r.store_width = 4'(n);
          r.store_addr = a + sx(64'({ir[31:25], ir[11:7]}), 12);
          r.store_data = (n < 8) ? (b & ((64'd1 << (8 * n)) - 1)) : b;
          mem_wr(r.store_addr, r.store_data, n);
        end
        OPC_OP: begin
          sh = b[5:0]; wr = 1'b1;
          if (ir[25]) v = mul_div(f3, a, b);
          else case (f3)
            3'd0: v = b30 ? a - b : a + b;
            3'd1: v = a << sh;
            3'd2: v = 64'($signed(a) < $signed(b));
            3'd3: v = 64'(a < b);
            3'd4: v = a ^ b;
            3'd5: v = b30 ? 64'($signed(a) >>> sh) : a >> sh;
            3'd6: v = a | b;
            default: v = a & b;
          endcase
        end
        OPC_LUI: begin v = sx(64'({ir[31:12], 12'd0}), 32); wr = 1'b1; end
        OPC_OP32: begin
          sh = {1'b0, b[4:0]};
          if (ir[25]) begin
            if (f3 == 3'd0) begin v = sx(a * b, 32); wr = 1'b1; end
            else if (f3 == 3'd4 || f3 == 3'd6) begin
              v = sx(mul_div(f3, sx(a, 32), sx(b, 32)), 32); wr = 1'b1;
            end else if (f3 == 3'd5 || f3 == 3'd7) begin
              v = sx(mul_div(f3, {32'd0, a[31:0]}, {32'd0, b[31:0]}), 32); wr = 1'b1;
            end
          end else if (f3 == 3'd0) begin
            v = sx(b30 ? a - b : a + b, 32); wr = 1'b1;
          end else if (f3 == 3'd1) begin
            v = sx(a << sh, 32); wr = 1'b1;
          end else if (f3 == 3'd5) begin
            v = b30 ? sx(64'($signed(sx(a, 32)) >>> sh), 32) : sx({32'd0, a[31:0]} >> sh, 32);
            wr = 1'b1;
          end
        end
        OPC_BRANCH: begin
          off = 64'({ir[31], ir[7], ir[30:25], ir[11:8], 1'b0});
          case (f3)
            3'd0: take = a == b;
            3'd1: take = a != b;
            3'd4: take = $signed(a) < $signed(b);
            3'd5: take = !($signed(a) < $signed(b));
            3'd6: take = a < b;
            3'd7: take = a >= b;
            default: take = 1'b0;
          endcase
          if (take) begin jump = 1'b1; target = pc_q + sx(off, 13); end
        end
        OPC_JALR: begin
          target = (a + imm) & ~64'd1; jump = 1'b1; v = pc_q + 4; wr = 1'b1;
        end
        OPC_JAL: begin
          off = 64'({ir[31], ir[19:12], ir[20], ir[30:21], 1'b0});
          target = pc_q + sx(off, 21); jump = 1'b1; v = pc_q + 4; wr = 1'b1;
        end
        default: ;
      endcase
      if (jump && !no_jump) npc = target;
    end
    if (wr && rd != 0) xreg[rd] = v;
    r.exec_pc = pc_q;
    r.next_pc = npc;
    r.dest_index = rd;
    r.dest_value = xreg[rd];
    pc_q = npc;
    expected_q.push_back(r);
  endtask

  // sends one request in bursts with random gaps
  task automatic send_request(input logic action, input logic [31:0] ir, input logic no_jump,
                              input logic [15:0] paddr, input logic [63:0] pdata);
    if (burst_left == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= action;
    s_axis_tdata_i  <= {7'd0, pdata, paddr, no_jump, ir};
    predict_step(action, ir, no_jump, paddr, pdata);
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic exec_instr(input logic [31:0] ir, input logic no_jump = 1'b0);
    send_request(1'b0, ir, no_jump, 16'($urandom), {$urandom, $urandom});
  endtask

  task automatic drain_and_idle();
    s_axis_tvalid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reset_pc(input logic [63:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    pc_q = value;
  endtask

  function automatic logic [31:0] enc_r(logic [4:0] opc, logic [6:0] f7, logic [2:0] f3,
                                        logic [4:0] rd, logic [4:0] r1, logic [4:0] r2);
    return {f7, r2, r1, f3, rd, opc, 2'b11};
  endfunction

  function automatic logic [31:0] enc_i(logic [4:0] opc, logic [11:0] im, logic [2:0] f3,
                                        logic [4:0] rd, logic [4:0] r1);
    return {im, r1, f3, rd, opc, 2'b11};
  endfunction

  function automatic logic [31:0] enc_s(logic [4:0] opc, logic [11:0] im, logic [2:0] f3,
                                        logic [4:0] r1, logic [4:0] r2);
    return {im[11:5], r2, r1, f3, im[4:0], opc, 2'b11};
  endfunction

  // random instruction, mostly with a known opcode and useful function bits
  function automatic logic [31:0] rand_instr();
    logic [4:0] opcs [11];
    logic [4:0] opc;
    logic [31:0] ir;
    int pick;
    opcs = '{OPC_LOAD, OPC_OPIMM, OPC_AUIPC, OPC_OPIMM32, OPC_STORE, OPC_OP,
             OPC_LUI, OPC_OP32, OPC_BRANCH, OPC_JALR, OPC_JAL};
    pick = $urandom_range(0, 99);
    ir = $urandom;
    if (pick < 4) return ir;
    if (pick < 7) return {ir[31:2], 2'b11};
    opc = opcs[$urandom_range(0, 10)];
    ir[6:0] = {opc, 2'b11};
    if (opc == OPC_OP || opc == OPC_OP32) begin
      ir[31:25] = ($urandom % 3 == 0) ? 7'b0000001 : {1'b0, 1'($urandom), 5'd0};
      // keep divides a minority so run time stays sane
      if (ir[25] && ir[14] && ($urandom % 3 != 0)) ir[14] = 1'b0;
    end
    if (opc == OPC_OPIMM && ir[13:12] == 2'b01) ir[31:26] = {1'b0, 1'($urandom), 4'd0};
    return ir;
  endfunction

  task automatic test_directed();
    // build some operands
    exec_instr(enc_i(OPC_OPIMM, 12'h7ff, 3'd0, 5'd1, 5'd0));
    exec_instr(enc_i(OPC_OPIMM, 12'h800, 3'd0, 5'd2, 5'd0));
    exec_instr({20'h80000, 5'd3, OPC_LUI, 2'b11});
    exec_instr(enc_i(OPC_OPIMM, 12'd32, 3'd1, 5'd4, 5'd3));  // 0x8000.. sign pattern
    exec_instr(enc_i(OPC_OPIMM, 12'hfff, 3'd0, 5'd5, 5'd0)); // -1
    exec_instr(enc_r(OPC_OP, 7'd1, 3'd4, 5'd6, 5'd4, 5'd5)); // div overflow
    exec_instr(enc_r(OPC_OP, 7'd1, 3'd6, 5'd7, 5'd4, 5'd5)); // rem overflow
    exec_instr(enc_r(OPC_OP, 7'd1, 3'd5, 5'd8, 5'd1, 5'd0)); // divide by zero
    exec_instr(enc_r(OPC_OP, 7'd1, 3'd7, 5'd9, 5'd1, 5'd0));
    exec_instr(enc_r(OPC_OP32, 7'd1, 3'd4, 5'd10, 5'd3, 5'd5));
    exec_instr(enc_r(OPC_OP, 7'd1, 3'd1, 5'd11, 5'd4, 5'd5));
    exec_instr(enc_r(OPC_OP, 7'h20, 3'd5, 5'd12, 5'd4, 5'd2)); // shift amount masked
    exec_instr(enc_s(OPC_STORE, 12'hfff, 3'd3, 5'd0, 5'd4));   // address wraps
    exec_instr(enc_i(OPC_LOAD, 12'hffd, 3'd2, 5'd13, 5'd0));
    exec_instr(enc_i(OPC_LOAD, 12'hfff, 3'd4, 5'd14, 5'd0));
    send_request(1'b1, 32'd0, 1'b0, 16'hfffc, 64'hfedc_ba98_7654_3210);
    exec_instr(enc_i(OPC_LOAD, 12'hffc, 3'd3, 5'd15, 5'd0));
    exec_instr(32'h0000_0000);                                // short encoding
    exec_instr(enc_i(5'h1c, 12'd0, 3'd0, 5'd1, 5'd0));        // system: nothing
    exec_instr({1'b1, 10'd0, 1'b0, 8'hff, 5'd1, OPC_JAL, 2'b11});
    exec_instr(enc_i(OPC_JALR, 12'h7ff, 3'd0, 5'd16, 5'd1), 1'b1);
    exec_instr(enc_i(OPC_JALR, 12'h001, 3'd0, 5'd0, 5'd1));
    exec_instr(enc_s(OPC_BRANCH, 12'hffe, 3'd0, 5'd0, 5'd0));
    exec_instr(enc_s(OPC_BRANCH, 12'h7fe, 3'd5, 5'd4, 5'd5), 1'b1);
    exec_instr({20'hfffff, 5'd17, OPC_AUIPC, 2'b11});
    drain_and_idle();
  endtask

  task automatic test_random(input int count);
    logic [63:0] pd;
    for (int i = 0; i < count; i++) begin
      if (($urandom % 10) == 0) begin
        pd = {$urandom, $urandom};
        send_request(1'b1, $urandom, 1'($urandom), 16'($urandom), pd);
      end else begin
        exec_instr(rand_instr(), ($urandom % 5) == 0);
      end
    end
    drain_and_idle();
  endtask

  initial begin
    burst_left      = 0;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = 1'b0;
    for (int i = 0; i < 32; i++) xreg[i] = '0;
    for (int i = 0; i < MEM_BYTES; i++) dmem[i] = '0;
    pc_q = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_reset_pc(64'h0);
    test_directed();
    write_reset_pc(64'hffff_ffff_ffff_fff0);
    test_random(600);
    write_reset_pc(64'h0000_0000_0001_0000);
    test_random(600);
    write_reset_pc({$urandom, $urandom});
    test_random(600);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
